@@ sv/cdsu_pkg.sv @@
// Shared types and constants of the call syntax delimiter scanner.
// Used by the step logic, the top level and the testbench.
package cdsu_pkg;

  typedef enum logic [5:0] {
    PH_LEAD = 6'b000001,
    PH_NAME = 6'b000010,
    PH_GAP  = 6'b000100,
    PH_ARGS = 6'b001000,
    PH_DONE = 6'b010000,
    PH_FAIL = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_SPACE   = 3'd0,
    ROLE_NAME    = 3'd1,
    ROLE_OPEN    = 3'd2,
    ROLE_KEPT    = 3'd3,
    ROLE_DROPPED = 3'd4,
    ROLE_CLOSE   = 3'd5,
    ROLE_TRAIL   = 3'd6,
    ROLE_ERROR   = 3'd7
  } role_e;

  typedef enum logic [1:0] {
    STAT_SCANNING = 2'd0,
    STAT_FOUND    = 2'd1,
    STAT_FAILED   = 2'd2
  } status_e;

  localparam logic REG_NAME_CAP = 1'b0;
  localparam logic REG_ARGS_CAP = 1'b1;

  localparam logic [5:0] NAME_CAP_RESET = 6'd63;
  localparam logic [9:0] ARGS_CAP_RESET = 10'd1023;
  localparam logic [9:0] ARG_COUNT_MAX  = 10'd1023;
  localparam logic [8:0] PAREN_MAX      = 9'h0FF;
  localparam logic [8:0] PAREN_MIN      = 9'h100;
  localparam logic [7:0] DEPTH_MAX      = 8'd255;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_payload_t;

  typedef struct packed {
    role_e      byte_role;
    logic [7:0] out_byte;
    logic [9:0] position;
    status_e    scan_status;
    logic [9:0] arg_length;
  } out_payload_t;

  typedef struct packed {
    phase_e     phase;
    logic [5:0] name_count;
    logic [9:0] arg_count;
    logic [8:0] paren_depth;
    logic [7:0] brace_depth;
    logic [7:0] bracket_depth;
    logic       in_quote;
    logic       escape_pending;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    phase:          PH_LEAD,
    name_count:     6'd0,
    arg_count:      10'd0,
    paren_depth:    9'd1,
    brace_depth:    8'd0,
    bracket_depth:  8'd0,
    in_quote:       1'b0,
    escape_pending: 1'b0
  };

endpackage

@@ sv/cdsu_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is supplied by the instantiating level.
interface cdsu_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

@@ sv/cdsu_step.sv @@
// Per-byte next-state and result logic of the delimiter scanner.
// Depends on cdsu_pkg for state, payload types and character codes.
module cdsu_step import cdsu_pkg::*; (
  input  scan_state_t  st_i,
  input  in_payload_t  item_i,
  input  logic [5:0]   name_cap_i,
  input  logic [9:0]   args_cap_i,
  output scan_state_t  st_o,
  output out_payload_t res_o
);

  logic       white;
  logic       closes;
  logic [7:0] c;

  assign c     = item_i.char_byte;
  assign white = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  always_comb begin
    st_o   = st_i;
    closes = 1'b0;
    res_o  = '{byte_role: ROLE_ERROR, out_byte: 8'd0, position: 10'd0,
               scan_status: STAT_SCANNING, arg_length: 10'd0};
    case (st_i.phase)
      PH_LEAD, PH_NAME, PH_GAP: begin
        if (white) begin
          res_o.byte_role = ROLE_SPACE;
          if (st_i.phase == PH_NAME) begin
            st_o.phase = PH_GAP;
          end
        end else if (c == CH_LPAREN) begin
          res_o.byte_role = ROLE_OPEN;
          st_o.phase      = PH_ARGS;
        end else if ((st_i.phase != PH_GAP) && (st_i.name_count < name_cap_i)) begin
          res_o.byte_role = ROLE_NAME;
          res_o.out_byte  = c;
          res_o.position  = {4'd0, st_i.name_count};
          st_o.name_count = st_i.name_count + 6'd1;
          st_o.phase      = PH_NAME;
        end else begin
          res_o.byte_role = ROLE_ERROR;
          st_o.phase      = PH_FAIL;
        end
      end
      PH_ARGS: begin
        if (st_i.in_quote) begin
          if (st_i.escape_pending) begin
            st_o.escape_pending = 1'b0;
          end else if (c == CH_BSLASH) begin
            st_o.escape_pending = 1'b1;
          end else if (c == CH_DQUOTE) begin
            st_o.in_quote = 1'b0;
          end
        end else begin
          case (c)
            CH_DQUOTE: st_o.in_quote = 1'b1;
            CH_LBRACE: begin
              if (st_i.brace_depth != DEPTH_MAX) begin
                st_o.brace_depth = st_i.brace_depth + 8'd1;
              end
            end
            CH_RBRACE: begin
              if (st_i.brace_depth != 8'd0) begin
                st_o.brace_depth = st_i.brace_depth - 8'd1;
              end
            end
            CH_LBRACK: begin
              if (st_i.bracket_depth != DEPTH_MAX) begin
                st_o.bracket_depth = st_i.bracket_depth + 8'd1;
              end
            end
            CH_RBRACK: begin
              if (st_i.bracket_depth != 8'd0) begin
                st_o.bracket_depth = st_i.bracket_depth - 8'd1;
              end
            end
            CH_LPAREN: begin
              if (st_i.paren_depth != PAREN_MAX) begin
                st_o.paren_depth = st_i.paren_depth + 9'd1;
              end
            end
            CH_RPAREN: begin
              if (st_i.paren_depth != PAREN_MIN) begin
                st_o.paren_depth = st_i.paren_depth - 9'd1;
              end
              closes = (st_o.paren_depth == 9'd0) && (st_i.brace_depth == 8'd0) &&
                       (st_i.bracket_depth == 8'd0);
            end
            default: ;
          endcase
        end
        if (closes) begin
          res_o.byte_role = ROLE_CLOSE;
          st_o.phase      = PH_DONE;
          if (st_i.arg_count > args_cap_i) begin
            st_o.arg_count = args_cap_i;
          end
        end else begin
          res_o.position = st_i.arg_count;
          if (st_i.arg_count < args_cap_i) begin
            res_o.byte_role = ROLE_KEPT;
            res_o.out_byte  = c;
          end else begin
            res_o.byte_role = ROLE_DROPPED;
          end
          if (st_i.arg_count != ARG_COUNT_MAX) begin
            st_o.arg_count = st_i.arg_count + 10'd1;
          end
        end
      end
      PH_DONE: res_o.byte_role = ROLE_TRAIL;
      default: begin
        res_o.byte_role = ROLE_ERROR;
        st_o.phase      = PH_FAIL;
      end
    endcase

    if (st_o.phase == PH_DONE) begin
      res_o.scan_status = STAT_FOUND;
      res_o.arg_length  = st_o.arg_count;
    end else if ((st_o.phase == PH_FAIL) || item_i.is_last) begin
      res_o.scan_status = STAT_FAILED;
    end

    if (item_i.is_last) begin
      st_o = SCAN_STATE_RESET;
    end
  end

endmodule

@@ sv/call_syntax_delimiter_scanner_unit.sv @@
// Call syntax delimiter scanner: one result per input byte.
// Each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result output is not stalled.
// Reset: capacities return to 63 and 1023, scan state to leading whitespace, both stages empty.
// Depends on cdsu_pkg, cdsu_stream_if and cdsu_step.
module call_syntax_delimiter_scanner_unit import cdsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [9:0]            cfg_data_i,
  cdsu_stream_if.sink           in_i,
  cdsu_stream_if.source         out_o
);

  logic         s1_valid_q;
  in_payload_t  s1_q;
  logic         out_valid_q;
  out_payload_t out_q;
  logic [5:0]   name_cap_q;
  logic [9:0]   args_cap_q;
  scan_state_t  st_q;
  scan_state_t  st_d;
  out_payload_t res_d;
  logic         adv;
  logic         in_ready;

  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  cdsu_step u_step (
    .st_i       (st_q),
    .item_i     (s1_q),
    .name_cap_i (name_cap_q),
    .args_cap_i (args_cap_q),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_cap_q <= NAME_CAP_RESET;
      args_cap_q <= ARGS_CAP_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NAME_CAP) begin
        name_cap_q <= cfg_data_i[5:0];
      end else begin
        args_cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= SCAN_STATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_q <= in_i.payload;
    end
    if (adv) begin
      out_q <= res_d;
    end
  end

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_q.is_last |=> (st_q.phase == PH_LEAD) && (st_q.paren_depth == 9'd1))
    else $error("scan state not rearmed after last byte");

  a_lead_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_LEAD |-> (st_q.name_count == 6'd0) && (st_q.arg_count == 10'd0))
    else $error("counts nonzero in leading whitespace phase");

  a_found_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.scan_status == STAT_FOUND) |->
      (out_q.byte_role == ROLE_CLOSE) || (out_q.byte_role == ROLE_TRAIL))
    else $error("found status on a byte that is neither close nor trailing");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> s1_valid_q && out_valid_q && !out_o.ready)
    else $error("input held off without a stalled result");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for call_syntax_delimiter_scanner_unit: a directed table of call texts, then
// random and deep-nesting texts, each result checked field by field against the table or a byte scanner.
// Depends on cdsu_pkg, cdsu_stream_if and the scanner RTL.
module tb;
  import cdsu_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 45;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    logic         typed;
    out_payload_t want;
  } dir_row_t;

  localparam out_payload_t NO_WANT = '0;

  localparam dir_row_t DIRECTED_ROWS [22] = '{
    '{CH_SPACE,  1'b0, 1'b1, '{ROLE_SPACE, 8'h00, 10'd0, STAT_SCANNING, 10'd0}},
    '{8'h66,     1'b0, 1'b1, '{ROLE_NAME,  8'h66, 10'd0, STAT_SCANNING, 10'd0}},
    '{CH_TAB,    1'b0, 1'b1, '{ROLE_SPACE, 8'h00, 10'd0, STAT_SCANNING, 10'd0}},
    '{CH_LPAREN, 1'b0, 1'b1, '{ROLE_OPEN,  8'h00, 10'd0, STAT_SCANNING, 10'd0}},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_WANT},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_LBRACE, 1'b0, 1'b0, NO_WANT},
    '{CH_LBRACK, 1'b0, 1'b0, NO_WANT},
    '{CH_RBRACK, 1'b0, 1'b0, NO_WANT},
    '{CH_RBRACE, 1'b0, 1'b0, NO_WANT},
    '{CH_RPAREN, 1'b0, 1'b0, NO_WANT},
    '{8'hFF,     1'b1, 1'b0, NO_WANT},
    '{8'h61,     1'b0, 1'b1, '{ROLE_NAME,  8'h61, 10'd0, STAT_SCANNING, 10'd0}},
    '{CH_SPACE,  1'b0, 1'b1, '{ROLE_SPACE, 8'h00, 10'd0, STAT_SCANNING, 10'd0}},
    '{8'h62,     1'b0, 1'b1, '{ROLE_ERROR, 8'h00, 10'd0, STAT_FAILED,   10'd0}},
    '{8'h01,     1'b1, 1'b1, '{ROLE_ERROR, 8'h00, 10'd0, STAT_FAILED,   10'd0}},
    '{CH_LPAREN, 1'b0, 1'b1, '{ROLE_OPEN,  8'h00, 10'd0, STAT_SCANNING, 10'd0}},
    '{8'h7A,     1'b1, 1'b1, '{ROLE_KEPT,  8'h7A, 10'd0, STAT_FAILED,   10'd0}},
    '{CH_CR,     1'b1, 1'b1, '{ROLE_SPACE, 8'h00, 10'd0, STAT_FAILED,   10'd0}},
    '{8'h80,     1'b1, 1'b1, '{ROLE_NAME,  8'h80, 10'd0, STAT_FAILED,   10'd0}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [9:0] cfg_data_i;

  cdsu_stream_if #(.payload_t(in_payload_t))  char_ch ();
  cdsu_stream_if #(.payload_t(out_payload_t)) result_ch ();

  call_syntax_delimiter_scanner_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (char_ch),
    .out_o      (result_ch)
  );

  always #4 clk_i = ~clk_i;

  logic [5:0] name_cap;
  logic [9:0] args_cap;
  phase_e     scan_phase;
  logic [5:0] name_len;
  logic [9:0] arg_len;
  logic [8:0] paren_lvl;
  logic [7:0] brace_lvl;
  logic [7:0] bracket_lvl;
  logic       in_string;
  logic       escape_next;

  out_payload_t awaited_results [$];
  in_payload_t  call_text [$];
  int           mismatch_count = 0;
  int           phase_items;
  logic         no_idle = 1'b0;
  logic         hold_off_req = 1'b0;

  function automatic void rearm_scan();
    scan_phase  = PH_LEAD;
    name_len    = '0;
    arg_len     = '0;
    paren_lvl   = 9'd1;
    brace_lvl   = '0;
    bracket_lvl = '0;
    in_string   = 1'b0;
    escape_next = 1'b0;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic out_payload_t predict_byte_result(logic [7:0] c, logic last);
    out_payload_t res;
    logic         closing;
    res = NO_WANT;
    res.byte_role = ROLE_ERROR;
    closing = 1'b0;
    case (scan_phase)
      PH_LEAD, PH_NAME, PH_GAP: begin
        if (is_blank(c)) begin
          res.byte_role = ROLE_SPACE;
          if (scan_phase == PH_NAME) scan_phase = PH_GAP;
        end else if (c == CH_LPAREN) begin
          res.byte_role = ROLE_OPEN;
          scan_phase = PH_ARGS;
        end else if (scan_phase != PH_GAP && name_len < name_cap) begin
          res.byte_role = ROLE_NAME;
          res.out_byte = c;
          res.position = 10'(name_len);
          name_len++;
          scan_phase = PH_NAME;
        end else begin
          scan_phase = PH_FAIL;
        end
      end
      PH_ARGS: begin
        if (in_string) begin
          if (escape_next) escape_next = 1'b0;
          else if (c == CH_BSLASH) escape_next = 1'b1;
          else if (c == CH_DQUOTE) in_string = 1'b0;
        end else begin
          case (c)
            CH_DQUOTE: in_string = 1'b1;
            CH_LBRACE: if (brace_lvl != DEPTH_MAX) brace_lvl++;
            CH_RBRACE: if (brace_lvl != 8'd0) brace_lvl--;
            CH_LBRACK: if (bracket_lvl != DEPTH_MAX) bracket_lvl++;
            CH_RBRACK: if (bracket_lvl != 8'd0) bracket_lvl--;
            CH_LPAREN: if (paren_lvl != PAREN_MAX) paren_lvl++;
            CH_RPAREN: begin
              if (paren_lvl != PAREN_MIN) paren_lvl--;
              closing = (paren_lvl == 9'd0) && (brace_lvl == 8'd0) && (bracket_lvl == 8'd0);
            end
            default: ;
          endcase
        end
        if (closing) begin
          res.byte_role = ROLE_CLOSE;
          if (arg_len > args_cap) arg_len = args_cap;
          scan_phase = PH_DONE;
        end else begin
          res.position = arg_len;
          if (arg_len < args_cap) begin
            res.byte_role = ROLE_KEPT;
            res.out_byte = c;
          end else begin
            res.byte_role = ROLE_DROPPED;
          end
          if (arg_len != ARG_COUNT_MAX) arg_len++;
        end
      end
      PH_DONE: res.byte_role = ROLE_TRAIL;
      default: scan_phase = PH_FAIL;
    endcase
    if (scan_phase == PH_DONE) begin
      res.scan_status = STAT_FOUND;
      res.arg_length = arg_len;
    end else if (scan_phase == PH_FAIL || last) begin
      res.scan_status = STAT_FAILED;
    end
    if (last) rearm_scan();
    return res;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void add_char(logic [7:0] c);
    call_text.push_back('{c, 1'b0});
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
  endfunction

  function automatic logic [7:0] plain_char();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return plain_char();
    do c = 8'($urandom_range(1, 255));
    while (is_blank(c) || c == CH_LPAREN);
    return c;
  endfunction

  task automatic gen_call_text();
    logic [7:0] closers [$];
    int         name_chars;
    call_text.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) add_char(blank_char());
      case ($urandom_range(0, 9))
        0: name_chars = int'(name_cap) + 1;
        1: name_chars = int'(name_cap);
        default: name_chars = $urandom_range(0, (name_cap < 6'd6) ? int'(name_cap) : 6);
      endcase
      repeat (name_chars) add_char(name_char());
      if ($urandom_range(0, 2) == 0) add_char(blank_char());
      if ($urandom_range(0, 19) == 0) add_char(name_char());
      add_char(CH_LPAREN);
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0: begin
            add_char(CH_LBRACE);
            closers.push_back(CH_RBRACE);
          end
          1: begin
            add_char(CH_LBRACK);
            closers.push_back(CH_RBRACK);
          end
          2: begin
            add_char(CH_LPAREN);
            closers.push_back(CH_RPAREN);
          end
          3: if (closers.size() > 0) add_char(closers.pop_back());
          4: begin
            add_char(CH_DQUOTE);
            repeat ($urandom_range(0, 4)) begin
              if ($urandom_range(0, 3) == 0) begin
                add_char(CH_BSLASH);
                add_char(8'($urandom_range(1, 255)));
              end else begin
                add_char(plain_char());
              end
            end
            add_char(CH_DQUOTE);
          end
          5: add_char(8'($urandom_range(1, 255)));
          default: add_char(plain_char());
        endcase
      end
      while (closers.size() > 0) add_char(closers.pop_back());
      if ($urandom_range(0, 9) != 0) add_char(CH_RPAREN);
      repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(1, 255)));
    end
    call_text[call_text.size() - 1].is_last = 1'b1;
  endtask

  task automatic gen_deep_text(int kind);
    call_text.delete();
    add_char(CH_LPAREN);
    case (kind)
      0: begin
        repeat (256) add_char(CH_LBRACE);
        repeat (258) add_char(CH_RPAREN);
        add_char(CH_RBRACE);
      end
      default: begin
        repeat (3) add_char(CH_RBRACE);
        repeat (3) add_char(CH_RBRACK);
        add_char(CH_LBRACK);
        add_char(CH_RBRACK);
        add_char(CH_LBRACE);
        add_char(CH_RBRACE);
        add_char(CH_RPAREN);
      end
    endcase
    call_text[call_text.size() - 1].is_last = 1'b1;
  endtask

  task automatic send_char(in_payload_t item);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      char_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_ch.valid   <= 1'b1;
    char_ch.payload <= item;
    do @(posedge clk_i);
    while (!char_ch.ready);
  endtask

  task automatic send_text();
    foreach (call_text[i]) begin
      send_char(call_text[i]);
      awaited_results.push_back(
        predict_byte_result(call_text[i].char_byte, call_text[i].is_last));
      phase_items++;
    end
  endtask

  task automatic write_config(logic [5:0] ncap, logic [9:0] acap);
    char_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_NAME_CAP;
    cfg_data_i <= {4'b0000, ncap};
    @(posedge clk_i);
    cfg_idx_i  <= REG_ARGS_CAP;
    cfg_data_i <= acap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    name_cap = ncap;
    args_cap = acap;
  endtask

  initial begin : stimulus
    logic [5:0]   name_caps [NUM_PHASES];
    logic [9:0]   args_caps [NUM_PHASES];
    out_payload_t want;
    name_caps = '{6'd63, 6'd1, 6'd2, 6'd63, 6'($urandom_range(1, 63)), 6'($urandom_range(1, 8))};
    args_caps = '{10'd1023, 10'd0, 10'd3, 10'd1023, 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 20))};
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_NAME_CAP;
    cfg_data_i      <= '0;
    char_ch.valid   <= 1'b0;
    char_ch.payload <= '0;
    name_cap = NAME_CAP_RESET;
    args_cap = ARGS_CAP_RESET;
    rearm_scan();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) write_config(name_caps[ph], args_caps[ph]);
      phase_items = 0;
      no_idle = (ph == 3);
      if (ph == 0) begin
        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
          send_char('{DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last});
          want = predict_byte_result(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last);
          awaited_results.push_back(DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want : want);
        end
      end
      if (ph == 1) hold_off_req = 1'b1;
      if (ph == 3) begin
        for (int k = 0; k < 2; k++) begin
          gen_deep_text(k);
          send_text();
        end
      end
      while (phase_items < PHASE_ITEMS) begin
        gen_call_text();
        send_text();
      end
    end
    char_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    int           hold_left;
    out_payload_t got;
    out_payload_t want;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing pending: role %0d byte %0d",
                 got.byte_role, got.out_byte);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("byte_role", want.byte_role, got.byte_role);
          compare_field("out_byte", want.out_byte, got.out_byte);
          compare_field("position", want.position, got.position);
          compare_field("scan_status", want.scan_status, got.scan_status);
          compare_field("arg_length", want.arg_length, got.arg_length);
        end
      end
      if (hold_off_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
